// ----- sv/krsp_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// krsp_pkg: shared definitions for the keyed record stream parser
// Field widths, character codes, parse phases, event codes and the
// request and result records passed between the parser stages.
// ============================================================================
package krsp_pkg;

    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 31;
    localparam int EVENT_W = 3;

    // A digit arriving while the accumulator is above this value is a format error.
    localparam logic [LEN_W-1:0] ACCUM_LIMIT = LEN_W'(214748363);

    localparam logic [BYTE_W-1:0] CH_PLUS    = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_COMMA   = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_COLON   = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_DASH    = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_GT      = 8'h3E;
    localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE    = 8'h39;

    typedef enum logic [3:0] {
        PH_START = 4'd0,
        PH_KLEN  = 4'd1,
        PH_DLEN  = 4'd2,
        PH_KEY   = 4'd3,
        PH_DASH  = 4'd4,
        PH_GT    = 4'd5,
        PH_DATA  = 4'd6,
        PH_NL    = 4'd7,
        PH_OK    = 4'd8,
        PH_ERR   = 4'd9
    } phase_t;

    typedef enum logic [EVENT_W-1:0] {
        EV_CONSUMED = 3'd0,
        EV_KEY      = 3'd1,
        EV_DATA     = 3'd2,
        EV_HEADER   = 3'd3,
        EV_RECORD   = 3'd4,
        EV_OK       = 3'd5,
        EV_ERROR    = 3'd6
    } event_t;

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              end_of_input;
    } item_t;

    typedef struct packed {
        event_t            event_res;
        logic [BYTE_W-1:0] byte_out;
        logic [LEN_W-1:0]  key_length;
        logic [LEN_W-1:0]  data_length;
    } result_t;

endpackage

// ----- sv/krsp_byte_if.sv -----
`timescale 1ns / 1ps
// ============================================================================
// krsp_byte_if: input byte channel
// Carries one stream byte or the end-of-input mark per request.
// ============================================================================
interface krsp_byte_if;
    logic                       valid;
    logic                       ready;
    logic [krsp_pkg::BYTE_W-1:0] in_byte;
    logic                       end_of_input;

    modport source (output valid, output in_byte, output end_of_input, input ready);
    modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

// ----- sv/krsp_event_if.sv -----
`timescale 1ns / 1ps
// ============================================================================
// krsp_event_if: parser event channel
// Carries one parse event with its byte and lengths per request.
// ============================================================================
interface krsp_event_if;
    logic                         valid;
    logic                         ready;
    logic [krsp_pkg::EVENT_W-1:0] event_res;
    logic [krsp_pkg::BYTE_W-1:0]  byte_out;
    logic [krsp_pkg::LEN_W-1:0]   key_length;
    logic [krsp_pkg::LEN_W-1:0]   data_length;

    modport source (output valid, output event_res, output byte_out,
                    output key_length, output data_length, input ready);
    modport sink   (input valid, input event_res, input byte_out,
                    input key_length, input data_length, output ready);
endinterface

// ----- sv/keyed_record_stream_parser.sv -----
`timescale 1ns / 1ps
// ============================================================================
// keyed_record_stream_parser: streaming parser for "+klen,dlen:key->data\n"
// Parses a byte stream of keyed records closed by a blank line and reports
// one event for every byte or end-of-input mark it receives.
// ============================================================================
// Usage:
//   The stream channel takes one request per cycle while ready: a raw byte,
//   or the end-of-input mark (with end_of_input high the byte is ignored).
//   The events channel returns exactly one event per request, in order:
//   consumed, key byte, data byte, header done (with both lengths), record
//   done, finished ok, or format error. Success and error are sticky; once
//   reached, every later request answers with the same event.
//   A request accepted into the input register is parsed out of it and its
//   event is shown from the result register. Throughput is one request per
//   cycle while the receiver keeps up, set by the phase update and the
//   shift-and-add length accumulator.
//   Reset puts the parser at the start of a record with both lengths and
//   the byte counter cleared, and empties both registers.
//   When the receiver stalls, the held event stays on the events channel,
//   the pending request waits in the input register, and stream.ready drops
//   once both registers are full; no request is lost or repeated.
// ============================================================================
module keyed_record_stream_parser (
    input  logic          clk,
    input  logic          rst_n,
    krsp_byte_if.sink     stream,
    krsp_event_if.source  events
);

    // Request waiting in the input register.
    logic              item_valid;
    krsp_pkg::item_t   item;

    // Parser result for that request.
    krsp_pkg::result_t res;

    // A request is parsed when it is present and the result register is free.
    logic              can_load;
    logic              step;

    assign step = item_valid && can_load;

    krsp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .stream     (stream),
        .take       (step),
        .item_valid (item_valid),
        .item       (item)
    );

    krsp_parser u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (item),
        .res   (res)
    );

    krsp_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (step),
        .res      (res),
        .can_load (can_load),
        .events   (events)
    );

endmodule

// ----- sv/krsp_in_stage.sv -----
`timescale 1ns / 1ps
// ============================================================================
// krsp_in_stage: input register
// Captures one request and holds it until the parser takes it.
// ============================================================================
module krsp_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    krsp_byte_if.sink         stream,
    input  logic              take,
    output logic              item_valid,
    output krsp_pkg::item_t   item
);

    logic            valid_reg;
    logic            valid_next;
    krsp_pkg::item_t item_reg;
    logic            accept;

    // Free when empty or when the held request leaves this cycle.
    assign stream.ready = !valid_reg || take;
    assign accept       = stream.valid && stream.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.in_byte      <= stream.in_byte;
            item_reg.end_of_input <= stream.end_of_input;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ----- sv/krsp_parser.sv -----
`timescale 1ns / 1ps
// ============================================================================
// krsp_parser: record format state machine
// Holds the parse phase, the length accumulator and the byte counter, and
// turns one request into one result combinationally.
// ============================================================================
module krsp_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  krsp_pkg::item_t   item,
    output krsp_pkg::result_t res
);

    krsp_pkg::phase_t                phase_reg;
    krsp_pkg::phase_t                phase_next;
    logic [krsp_pkg::LEN_W-1:0]      accum_reg;
    logic [krsp_pkg::LEN_W-1:0]      accum_next;
    logic                            seen_reg;
    logic                            seen_next;
    logic [krsp_pkg::LEN_W-1:0]      held_key_reg;
    logic [krsp_pkg::LEN_W-1:0]      held_key_next;
    logic [krsp_pkg::LEN_W-1:0]      held_data_reg;
    logic [krsp_pkg::LEN_W-1:0]      held_data_next;
    logic [krsp_pkg::LEN_W-1:0]      left_reg;
    logic [krsp_pkg::LEN_W-1:0]      left_next;

    logic [krsp_pkg::BYTE_W-1:0]     c;
    logic                            is_digit;
    logic                            fail;
    logic [krsp_pkg::LEN_W-1:0]      accum_mac;
    logic [krsp_pkg::LEN_W-1:0]      left_dec;

    assign c        = item.in_byte;
    assign is_digit = (c >= krsp_pkg::CH_ZERO) && (c <= krsp_pkg::CH_NINE);
    // accum * 10 + digit, kept to 31 bits; a digit's value is its low nibble.
    assign accum_mac = (accum_reg << 3) + (accum_reg << 1)
                     + {{(krsp_pkg::LEN_W-4){1'b0}}, c[3:0]};
    assign left_dec  = left_reg - {{(krsp_pkg::LEN_W-1){1'b0}}, 1'b1};

    // Format error detection for the current phase.
    always_comb
    begin
        fail = 1'b0;
        if (phase_reg == krsp_pkg::PH_OK)
        begin
            fail = 1'b0;
        end
        else if (phase_reg == krsp_pkg::PH_ERR || item.end_of_input)
        begin
            fail = 1'b1;
        end
        else
        begin
            unique case (phase_reg)
                krsp_pkg::PH_START:
                    fail = (c != krsp_pkg::CH_PLUS) && (c != krsp_pkg::CH_NEWLINE);
                krsp_pkg::PH_KLEN:
                    fail = is_digit ? (accum_reg > krsp_pkg::ACCUM_LIMIT)
                                    : (!seen_reg || c != krsp_pkg::CH_COMMA);
                krsp_pkg::PH_DLEN:
                    fail = is_digit ? (accum_reg > krsp_pkg::ACCUM_LIMIT)
                                    : (!seen_reg || c != krsp_pkg::CH_COLON);
                krsp_pkg::PH_KEY:  fail = 1'b0;
                krsp_pkg::PH_DASH: fail = (c != krsp_pkg::CH_DASH);
                krsp_pkg::PH_GT:   fail = (c != krsp_pkg::CH_GT);
                krsp_pkg::PH_DATA: fail = 1'b0;
                krsp_pkg::PH_NL:   fail = (c != krsp_pkg::CH_NEWLINE);
                default:           fail = 1'b1;
            endcase
        end
    end

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        if (fail)
        begin
            phase_next = krsp_pkg::PH_ERR;
        end
        else
        begin
            unique case (phase_reg)
                krsp_pkg::PH_START:
                    phase_next = (c == krsp_pkg::CH_PLUS) ? krsp_pkg::PH_KLEN
                                                          : krsp_pkg::PH_OK;
                krsp_pkg::PH_KLEN:
                    phase_next = is_digit ? krsp_pkg::PH_KLEN : krsp_pkg::PH_DLEN;
                krsp_pkg::PH_DLEN:
                begin
                    if (is_digit)
                    begin
                        phase_next = krsp_pkg::PH_DLEN;
                    end
                    else
                    begin
                        phase_next = (held_key_reg != '0) ? krsp_pkg::PH_KEY
                                                          : krsp_pkg::PH_DASH;
                    end
                end
                krsp_pkg::PH_KEY:
                    phase_next = (left_dec == '0) ? krsp_pkg::PH_DASH : krsp_pkg::PH_KEY;
                krsp_pkg::PH_DASH: phase_next = krsp_pkg::PH_GT;
                krsp_pkg::PH_GT:
                    phase_next = (held_data_reg != '0) ? krsp_pkg::PH_DATA
                                                       : krsp_pkg::PH_NL;
                krsp_pkg::PH_DATA:
                    phase_next = (left_dec == '0) ? krsp_pkg::PH_NL : krsp_pkg::PH_DATA;
                krsp_pkg::PH_NL:   phase_next = krsp_pkg::PH_START;
                krsp_pkg::PH_OK:   phase_next = krsp_pkg::PH_OK;
                default:           phase_next = krsp_pkg::PH_ERR;
            endcase
        end
    end

    // Result and datapath updates.
    always_comb
    begin
        res.event_res   = krsp_pkg::EV_CONSUMED;
        res.byte_out    = '0;
        res.key_length  = '0;
        res.data_length = '0;
        accum_next      = accum_reg;
        seen_next       = seen_reg;
        held_key_next   = held_key_reg;
        held_data_next  = held_data_reg;
        left_next       = left_reg;
        if (fail)
        begin
            res.event_res = krsp_pkg::EV_ERROR;
        end
        else
        begin
            unique case (phase_reg) inside
                krsp_pkg::PH_START:
                begin
                    if (c == krsp_pkg::CH_PLUS)
                    begin
                        accum_next = '0;
                        seen_next  = 1'b0;
                    end
                    else
                    begin
                        res.event_res = krsp_pkg::EV_OK;
                    end
                end
                krsp_pkg::PH_KLEN, krsp_pkg::PH_DLEN:
                begin
                    if (is_digit)
                    begin
                        accum_next = accum_mac;
                        seen_next  = 1'b1;
                    end
                    else
                    begin
                        accum_next = '0;
                        seen_next  = 1'b0;
                        if (phase_reg == krsp_pkg::PH_KLEN)
                        begin
                            held_key_next = accum_reg;
                        end
                        else
                        begin
                            held_data_next  = accum_reg;
                            left_next       = held_key_reg;
                            res.event_res   = krsp_pkg::EV_HEADER;
                            res.key_length  = held_key_reg;
                            res.data_length = accum_reg;
                        end
                    end
                end
                krsp_pkg::PH_KEY:
                begin
                    left_next     = left_dec;
                    res.event_res = krsp_pkg::EV_KEY;
                    res.byte_out  = c;
                end
                krsp_pkg::PH_GT:
                begin
                    left_next = held_data_reg;
                end
                krsp_pkg::PH_DATA:
                begin
                    left_next     = left_dec;
                    res.event_res = krsp_pkg::EV_DATA;
                    res.byte_out  = c;
                end
                krsp_pkg::PH_NL:
                begin
                    res.event_res = krsp_pkg::EV_RECORD;
                end
                krsp_pkg::PH_OK:
                begin
                    res.event_res = krsp_pkg::EV_OK;
                end
                default:
                begin
                    res.event_res = krsp_pkg::EV_CONSUMED;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= krsp_pkg::PH_START;
            accum_reg     <= '0;
            seen_reg      <= 1'b0;
            held_key_reg  <= '0;
            held_data_reg <= '0;
            left_reg      <= '0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            accum_reg     <= accum_next;
            seen_reg      <= seen_next;
            held_key_reg  <= held_key_next;
            held_data_reg <= held_data_next;
            left_reg      <= left_next;
        end
    end

endmodule

// ----- sv/krsp_out_stage.sv -----
`timescale 1ns / 1ps
// ============================================================================
// krsp_out_stage: result register
// Holds one parse event until the receiver takes it.
// ============================================================================
module krsp_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  krsp_pkg::result_t res,
    output logic              can_load,
    krsp_event_if.source      events
);

    logic              valid_reg;
    logic              valid_next;
    krsp_pkg::result_t res_reg;

    // The register may be refilled in the same cycle its content is taken.
    assign can_load = !valid_reg || events.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (events.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign events.valid       = valid_reg;
    assign events.event_res   = res_reg.event_res;
    assign events.byte_out    = res_reg.byte_out;
    assign events.key_length  = res_reg.key_length;
    assign events.data_length = res_reg.data_length;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_top: self-checking bench for the keyed record stream parser
// Feeds a stream of well-formed "+klen,dlen:key->data\n" records with random
// lengths, leading zeros and payload bytes, then closes the stream with one
// randomly chosen ending (blank line, early end, bad byte, overlong or empty
// length) and a tail that checks the sticky final answer. Every event the
// parser returns is compared field by field with a bit-accurate prediction.
// ============================================================================
module tb_top;

    localparam int BYTE_W = krsp_pkg::BYTE_W;
    localparam int LEN_W  = krsp_pkg::LEN_W;

    // ------------------------------------------------------------------------
    // Event board: predicts the parser event for every accepted request and
    // checks the events that come back, in order.
    // ------------------------------------------------------------------------
    class record_event_board;

        krsp_pkg::phase_t  parse_phase;
        logic [LEN_W-1:0]  length_accum;
        logic              digit_seen;
        logic [LEN_W-1:0]  key_len;
        logic [LEN_W-1:0]  data_len;
        logic [LEN_W-1:0]  bytes_left;
        krsp_pkg::result_t expected_events[$];
        int                mismatch_count;

        function new();
            parse_phase    = krsp_pkg::PH_START;
            length_accum   = '0;
            digit_seen     = 1'b0;
            key_len        = '0;
            data_len       = '0;
            bytes_left     = '0;
            mismatch_count = 0;
        endfunction

        // Advances the predicted parser state by one request and returns the
        // event that request must produce.
        function krsp_pkg::result_t parse_byte(logic [BYTE_W-1:0] c, logic eoi);
            krsp_pkg::result_t ev;
            logic              is_digit;
            logic              bad;
            logic [31:0]       grown;
            ev           = '0;
            ev.event_res = krsp_pkg::EV_CONSUMED;
            is_digit     = (c >= krsp_pkg::CH_ZERO) && (c <= krsp_pkg::CH_NINE);
            bad          = 1'b0;
            if (parse_phase == krsp_pkg::PH_OK)
            begin
                ev.event_res = krsp_pkg::EV_OK;
                return ev;
            end
            if (parse_phase == krsp_pkg::PH_ERR || eoi)
            begin
                parse_phase  = krsp_pkg::PH_ERR;
                ev.event_res = krsp_pkg::EV_ERROR;
                return ev;
            end
            case (parse_phase) inside
                krsp_pkg::PH_START:
                begin
                    if (c == krsp_pkg::CH_PLUS)
                    begin
                        parse_phase  = krsp_pkg::PH_KLEN;
                        length_accum = '0;
                        digit_seen   = 1'b0;
                    end
                    else if (c == krsp_pkg::CH_NEWLINE)
                    begin
                        parse_phase  = krsp_pkg::PH_OK;
                        ev.event_res = krsp_pkg::EV_OK;
                    end
                    else
                    begin
                        bad = 1'b1;
                    end
                end
                krsp_pkg::PH_KLEN, krsp_pkg::PH_DLEN:
                begin
                    if (is_digit)
                    begin
                        if (length_accum > krsp_pkg::ACCUM_LIMIT)
                        begin
                            bad = 1'b1;
                        end
                        else
                        begin
                            grown = 32'(length_accum) * 32'd10
                                  + 32'(c - krsp_pkg::CH_ZERO);
                            length_accum = grown[LEN_W-1:0];
                            digit_seen   = 1'b1;
                        end
                    end
                    else if (!digit_seen)
                    begin
                        bad = 1'b1;
                    end
                    else if (parse_phase == krsp_pkg::PH_KLEN)
                    begin
                        if (c != krsp_pkg::CH_COMMA)
                        begin
                            bad = 1'b1;
                        end
                        else
                        begin
                            key_len      = length_accum;
                            length_accum = '0;
                            digit_seen   = 1'b0;
                            parse_phase  = krsp_pkg::PH_DLEN;
                        end
                    end
                    else if (c != krsp_pkg::CH_COLON)
                    begin
                        bad = 1'b1;
                    end
                    else
                    begin
                        data_len       = length_accum;
                        length_accum   = '0;
                        digit_seen     = 1'b0;
                        bytes_left     = key_len;
                        parse_phase    = (key_len != 0) ? krsp_pkg::PH_KEY
                                                        : krsp_pkg::PH_DASH;
                        ev.event_res   = krsp_pkg::EV_HEADER;
                        ev.key_length  = key_len;
                        ev.data_length = data_len;
                    end
                end
                krsp_pkg::PH_KEY:
                begin
                    bytes_left = bytes_left - 1'b1;
                    if (bytes_left == 0) parse_phase = krsp_pkg::PH_DASH;
                    ev.event_res = krsp_pkg::EV_KEY;
                    ev.byte_out  = c;
                end
                krsp_pkg::PH_DASH:
                begin
                    if (c != krsp_pkg::CH_DASH) bad = 1'b1;
                    else parse_phase = krsp_pkg::PH_GT;
                end
                krsp_pkg::PH_GT:
                begin
                    if (c != krsp_pkg::CH_GT)
                    begin
                        bad = 1'b1;
                    end
                    else
                    begin
                        bytes_left  = data_len;
                        parse_phase = (data_len != 0) ? krsp_pkg::PH_DATA
                                                      : krsp_pkg::PH_NL;
                    end
                end
                krsp_pkg::PH_DATA:
                begin
                    bytes_left = bytes_left - 1'b1;
                    if (bytes_left == 0) parse_phase = krsp_pkg::PH_NL;
                    ev.event_res = krsp_pkg::EV_DATA;
                    ev.byte_out  = c;
                end
                krsp_pkg::PH_NL:
                begin
                    if (c != krsp_pkg::CH_NEWLINE)
                    begin
                        bad = 1'b1;
                    end
                    else
                    begin
                        parse_phase  = krsp_pkg::PH_START;
                        ev.event_res = krsp_pkg::EV_RECORD;
                    end
                end
                default: bad = 1'b1;
            endcase
            if (bad)
            begin
                parse_phase  = krsp_pkg::PH_ERR;
                ev           = '0;
                ev.event_res = krsp_pkg::EV_ERROR;
            end
            return ev;
        endfunction

        function void note_request(logic [BYTE_W-1:0] c, logic eoi);
            expected_events.push_back(parse_byte(c, eoi));
        endfunction

        function void compare_field(string name, logic [31:0] exp, logic [31:0] act);
            if (act !== exp)
            begin
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp, act);
                mismatch_count++;
            end
        endfunction

        function void check_event(krsp_pkg::result_t got);
            krsp_pkg::result_t exp;
            if (expected_events.size() == 0)
            begin
                $display("%0t: unexpected event: expected none, actual event %0d",
                         $time, got.event_res);
                mismatch_count++;
                return;
            end
            exp = expected_events.pop_front();
            compare_field("event_res", 32'(exp.event_res), 32'(got.event_res));
            compare_field("byte_out", 32'(exp.byte_out), 32'(got.byte_out));
            compare_field("key_length", 32'(exp.key_length), 32'(got.key_length));
            compare_field("data_length", 32'(exp.data_length), 32'(got.data_length));
        endfunction

        function int pending();
            return expected_events.size();
        endfunction

    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the parser itself.
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n;

    always #4 clk = ~clk;

    krsp_byte_if  stream_ch ();
    krsp_event_if event_ch ();

    keyed_record_stream_parser i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream_ch),
        .events (event_ch)
    );

    record_event_board board = new();

    // Idle rates in percent; the stimulus process changes them between phases.
    int send_idle_pct = 21;
    int recv_idle_pct = 88;

    // Number of requests accepted so far, used to pace the stimulus phases.
    int requests_sent = 0;

    // ------------------------------------------------------------------------
    // Event receiver: ready is rerolled every cycle at the current idle rate.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            event_ch.ready <= 1'b0;
        end
        else
        begin
            event_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Every handshake on the event channel is checked against the oldest
    // prediction. Values are sampled as they stood before the edge.
    always @(posedge clk)
    begin
        if (rst_n && event_ch.valid && event_ch.ready)
        begin
            board.check_event('{krsp_pkg::event_t'(event_ch.event_res), event_ch.byte_out,
                                event_ch.key_length, event_ch.data_length});
        end
    end

    // ------------------------------------------------------------------------
    // Stream driver tasks.
    // ------------------------------------------------------------------------

    // Presents one request and returns at the edge where it is taken. Valid is
    // left high on return, so back-to-back requests need no extra assignment;
    // it is lowered when the next call decides to idle or the stream is held off.
    task automatic send_request(input logic [BYTE_W-1:0] b, input logic eoi);
        while ($urandom_range(99) < send_idle_pct)
        begin
            stream_ch.valid <= 1'b0;
            @(posedge clk);
        end
        stream_ch.valid        <= 1'b1;
        stream_ch.in_byte      <= b;
        stream_ch.end_of_input <= eoi;
        do @(posedge clk); while (!stream_ch.ready);
        board.note_request(b, eoi);
        requests_sent++;
    endtask

    // Holds the stream off until the parser has answered everything.
    task automatic drain_events();
        stream_ch.valid <= 1'b0;
        do @(posedge clk); while (board.pending() != 0);
    endtask

    // Sends a decimal length, optionally with leading zeros.
    task automatic send_length(input int unsigned value, input int lead_zeros);
        logic [BYTE_W-1:0] digits[$];
        int unsigned       v;
        v = value;
        do
        begin
            digits.push_front(BYTE_W'(krsp_pkg::CH_ZERO + v % 10));
            v = v / 10;
        end while (v != 0);
        repeat (lead_zeros) send_request(krsp_pkg::CH_ZERO, 1'b0);
        foreach (digits[i]) send_request(digits[i], 1'b0);
    endtask

    // Key and data bytes are random, with a good share of the format
    // characters so that the parser is seen to pass them through untouched.
    function automatic logic [BYTE_W-1:0] payload_byte();
        logic [BYTE_W-1:0] specials[8];
        specials = '{krsp_pkg::CH_PLUS, krsp_pkg::CH_COMMA, krsp_pkg::CH_COLON,
                     krsp_pkg::CH_DASH, krsp_pkg::CH_GT, krsp_pkg::CH_NEWLINE,
                     krsp_pkg::CH_ZERO, krsp_pkg::CH_NINE};
        if ($urandom_range(3) == 0) return specials[$urandom_range(7)];
        return BYTE_W'($urandom_range(255));
    endfunction

    // Any byte except a, b and, if no_digit, the digits; for the unexpected byte endings.
    function automatic logic [BYTE_W-1:0] byte_other_than(logic [BYTE_W-1:0] a,
                                                          logic [BYTE_W-1:0] b,
                                                          logic              no_digit);
        logic [BYTE_W-1:0] c;
        do c = BYTE_W'($urandom_range(255));
        while (c == a || c == b ||
               (no_digit && c >= krsp_pkg::CH_ZERO && c <= krsp_pkg::CH_NINE));
        return c;
    endfunction

    // One complete well-formed record.
    task automatic send_record(input int unsigned klen, input int unsigned dlen,
                               input int kzeros, input int dzeros);
        send_request(krsp_pkg::CH_PLUS, 1'b0);
        send_length(klen, kzeros);
        send_request(krsp_pkg::CH_COMMA, 1'b0);
        send_length(dlen, dzeros);
        send_request(krsp_pkg::CH_COLON, 1'b0);
        repeat (klen) send_request(payload_byte(), 1'b0);
        send_request(krsp_pkg::CH_DASH, 1'b0);
        send_request(krsp_pkg::CH_GT, 1'b0);
        repeat (dlen) send_request(payload_byte(), 1'b0);
        send_request(krsp_pkg::CH_NEWLINE, 1'b0);
    endtask

    // A record of random shape: mostly short, now and then a long one, and
    // occasionally lengths written with leading zeros.
    task automatic send_random_record();
        int unsigned klen;
        int unsigned dlen;
        int          kzeros;
        int          dzeros;
        klen   = ($urandom_range(15) == 0) ? $urandom_range(60) : $urandom_range(6);
        dlen   = ($urandom_range(15) == 0) ? $urandom_range(60) : $urandom_range(10);
        kzeros = ($urandom_range(7) == 0) ? $urandom_range(1, 10) : 0;
        dzeros = ($urandom_range(7) == 0) ? $urandom_range(1, 10) : 0;
        send_record(klen, dlen, kzeros, dzeros);
    endtask

    // Success and format error are both sticky and reset happens only once,
    // so the stream can end in just one way per run. The seed picks which.
    task automatic close_stream();
        int                how;
        int                where;
        logic [BYTE_W-1:0] bad_digit;
        how   = $urandom_range(5);
        where = $urandom_range(4);
        bad_digit = BYTE_W'($urandom_range(krsp_pkg::CH_NINE, krsp_pkg::CH_ZERO));
        case (how) inside
            0:
            begin
                // Blank line at a record start: the only successful ending.
                send_request(krsp_pkg::CH_NEWLINE, 1'b0);
            end
            1:
            begin
                // End of input at a record start, or cut short inside a record.
                if (where != 0)
                begin
                    send_request(krsp_pkg::CH_PLUS, 1'b0);
                    send_length($urandom_range(99), 0);
                    if (where > 1) send_request(krsp_pkg::CH_COMMA, 1'b0);
                    if (where > 2) send_request(krsp_pkg::CH_NINE, 1'b0);
                    if (where > 3) send_request(krsp_pkg::CH_COLON, 1'b0);
                end
                send_request(payload_byte(), 1'b1);
            end
            2:
            begin
                // Unexpected byte in one of the phases that check the format.
                case (where)
                    0: send_request(byte_other_than(krsp_pkg::CH_PLUS,
                                                    krsp_pkg::CH_NEWLINE, 1'b0), 1'b0);
                    1:
                    begin
                        send_request(krsp_pkg::CH_PLUS, 1'b0);
                        send_length($urandom_range(20), 0);
                        send_request(byte_other_than(krsp_pkg::CH_COMMA,
                                                     krsp_pkg::CH_COMMA, 1'b1), 1'b0);
                    end
                    2:
                    begin
                        send_request(krsp_pkg::CH_PLUS, 1'b0);
                        send_length(1, 0);
                        send_request(krsp_pkg::CH_COMMA, 1'b0);
                        send_length(2, 0);
                        send_request(byte_other_than(krsp_pkg::CH_COLON,
                                                     krsp_pkg::CH_COLON, 1'b1), 1'b0);
                    end
                    3:
                    begin
                        send_request(krsp_pkg::CH_PLUS, 1'b0);
                        send_length(2, 0);
                        send_request(krsp_pkg::CH_COMMA, 1'b0);
                        send_length(0, 0);
                        send_request(krsp_pkg::CH_COLON, 1'b0);
                        repeat (2) send_request(payload_byte(), 1'b0);
                        if ($urandom_range(1) == 0)
                        begin
                            send_request(byte_other_than(krsp_pkg::CH_DASH,
                                                         krsp_pkg::CH_DASH, 1'b0), 1'b0);
                        end
                        else
                        begin
                            send_request(krsp_pkg::CH_DASH, 1'b0);
                            send_request(byte_other_than(krsp_pkg::CH_GT,
                                                         krsp_pkg::CH_GT, 1'b0), 1'b0);
                        end
                    end
                    default:
                    begin
                        send_request(krsp_pkg::CH_PLUS, 1'b0);
                        send_length(0, 0);
                        send_request(krsp_pkg::CH_COMMA, 1'b0);
                        send_length(3, 0);
                        send_request(krsp_pkg::CH_COLON, 1'b0);
                        send_request(krsp_pkg::CH_DASH, 1'b0);
                        send_request(krsp_pkg::CH_GT, 1'b0);
                        repeat (3) send_request(payload_byte(), 1'b0);
                        send_request(byte_other_than(krsp_pkg::CH_NEWLINE,
                                                     krsp_pkg::CH_NEWLINE, 1'b0), 1'b0);
                    end
                endcase
            end
            3, 4:
            begin
                // Too many digits, in the key or the data length. The length sent is
                // the largest legal one or 214748364; one more digit must be refused.
                send_request(krsp_pkg::CH_PLUS, 1'b0);
                if (where[0])
                begin
                    send_length(1, 0);
                    send_request(krsp_pkg::CH_COMMA, 1'b0);
                end
                send_length((where > 1) ? 32'd2147483639 : 32'd214748364, 0);
                send_request(bad_digit, 1'b0);
            end
            default:
            begin
                // Empty length: a separator before any digit.
                send_request(krsp_pkg::CH_PLUS, 1'b0);
                if (where[0])
                begin
                    send_length($urandom_range(9), 0);
                    send_request(krsp_pkg::CH_COMMA, 1'b0);
                    send_request(krsp_pkg::CH_COLON, 1'b0);
                end
                else
                begin
                    send_request(krsp_pkg::CH_COMMA, 1'b0);
                end
            end
        endcase
        // Once finished, every later request gets the same answer, including
        // bytes that would otherwise be meaningful and further end marks.
        repeat (16)
        begin
            if ($urandom_range(3) == 0)
                send_request(krsp_pkg::CH_PLUS, 1'($urandom_range(1)));
            else
                send_request(BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n                  = 1'b0;
        stream_ch.valid        <= 1'b0;
        stream_ch.in_byte      <= '0;
        stream_ch.end_of_input <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed records: both lengths zero, then a one-byte key with a
        // leading zero in its length carrying the extreme byte values.
        send_record(0, 0, 0, 0);
        send_request(krsp_pkg::CH_PLUS, 1'b0);
        send_length(1, 1);
        send_request(krsp_pkg::CH_COMMA, 1'b0);
        send_length(2, 0);
        send_request(krsp_pkg::CH_COLON, 1'b0);
        send_request(8'hFF, 1'b0);
        send_request(krsp_pkg::CH_DASH, 1'b0);
        send_request(krsp_pkg::CH_GT, 1'b0);
        send_request(8'h00, 1'b0);
        send_request(8'hFF, 1'b0);
        send_request(krsp_pkg::CH_NEWLINE, 1'b0);

        // Random records under a slow receiver.
        while (requests_sent < 150) send_random_record();

        // Let the parser run dry once before the rates swap.
        drain_events();
        send_idle_pct = 88;
        recv_idle_pct = 21;
        while (requests_sent < 300) send_random_record();

        // Full speed on both sides.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (requests_sent < 430) send_random_record();

        close_stream();
        stream_ch.valid <= 1'b0;

        // Wait for the last events, then keep the clock running so that any stray
        // event from the two-stage pipeline would still be caught.
        while (board.pending() != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        if (board.mismatch_count == 0)
        begin
            $display("** keyed_record_stream_parser: PASSED **");
        end
        else
        begin
            $display("** keyed_record_stream_parser: FAILED **");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run of this stimulus.
    initial
    begin
        #2_000_000;
        $display("%0t: timeout with %0d events outstanding", $time, board.pending());
        $display("** keyed_record_stream_parser: FAILED **");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/krsp_pkg.sv
sv/krsp_byte_if.sv
sv/krsp_event_if.sv
sv/krsp_in_stage.sv
sv/krsp_parser.sv
sv/krsp_out_stage.sv
sv/keyed_record_stream_parser.sv
tb/tb_top.sv
